FILE: hw/rtl/bsv_pkg.sv
// ----------------------------------------------------------------------------
// bsv_pkg
// Shared widths, character codes, error codes and beat types of the bencode
// stream validator.
// ----------------------------------------------------------------------------
package bsv_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned DEPTH_W = 7;

  // default nesting limit, 1 .. 2**DEPTH_W - 1
  localparam int unsigned BSV_MAX_DEPTH = 64;

  // bencode token characters
  localparam logic [DATA_W-1:0] CH_INT   = 8'h69; // 'i'
  localparam logic [DATA_W-1:0] CH_END   = 8'h65; // 'e'
  localparam logic [DATA_W-1:0] CH_LIST  = 8'h6c; // 'l'
  localparam logic [DATA_W-1:0] CH_DICT  = 8'h64; // 'd'
  localparam logic [DATA_W-1:0] CH_COLON = 8'h3a; // ':'
  localparam logic [DATA_W-1:0] CH_MINUS = 8'h2d; // '-'
  localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [DATA_W-1:0] CH_NINE  = 8'h39; // '9'

  typedef enum logic [CODE_W-1:0] {
    ERR_NONE     = 3'd0,
    ERR_BAD_BYTE = 3'd1,
    ERR_TRUNC    = 3'd2,
    ERR_TRAIL    = 3'd3,
    ERR_TOP      = 3'd4,
    ERR_DEPTH    = 3'd5,
    ERR_LEN_OVF  = 3'd6
  } err_code_e;

  // registered input beat handed to the parser
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } byte_beat_t;

endpackage

FILE: hw/rtl/bsv_if.sv
// ----------------------------------------------------------------------------
// bsv_if
// Valid/ready channel interfaces: stream bytes in, validation results out.
// ----------------------------------------------------------------------------
interface bsv_byte_if import bsv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsv_result_if import bsv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              stream_valid;
  logic [CODE_W-1:0] error_code;
  logic [POS_W-1:0]  error_offset;

  modport source (output valid, output stream_valid, output error_code,
                  output error_offset, input ready);
  modport sink   (input valid, input stream_valid, input error_code,
                  input error_offset, output ready);
endinterface

FILE: hw/rtl/bsv_parser.sv
// ----------------------------------------------------------------------------
// bsv_parser
// Per-byte bencode parse state, first-error latch and result register.
// ----------------------------------------------------------------------------
module bsv_parser import bsv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = BSV_MAX_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  byte_beat_t          beat_i,
  output logic                beat_ready_o,
  bsv_result_if.source        out_o
);

  typedef enum logic [2:0] {
    PH_TOP   = 3'd0,
    PH_VALUE = 3'd1,
    PH_INT   = 3'd2,
    PH_LEN   = 3'd3,
    PH_BODY  = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  localparam logic [DEPTH_W-1:0] DepthLimit = DEPTH_W'(MAX_DEPTH);

  phase_e             phase_q, phase_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  err_code_e          code_q, code_d;
  logic [POS_W-1:0]   off_q, off_d;

  logic               res_valid_q, res_valid_d;
  err_code_e          res_code_q, res_code_d;
  logic [POS_W-1:0]   res_off_q, res_off_d;

  logic               fire;
  logic               flag;
  err_code_e          flag_code;
  logic               is_digit;
  logic [3:0]         digit;
  logic [CNT_W+3:0]   len_next;
  logic               is_open;
  logic               depth_full;
  err_code_e          fin_code;
  logic [POS_W-1:0]   fin_off;

  // a beat may enter unless it would produce a result that has nowhere to go
  assign beat_ready_o = !beat_i.last_byte || !res_valid_q || out_o.ready;
  assign fire         = beat_i.valid && beat_ready_o;

  // byte classification and length accumulate (x*10 = x*8 + x*2)
  assign is_digit   = (beat_i.data_byte >= CH_ZERO) && (beat_i.data_byte <= CH_NINE);
  assign digit      = beat_i.data_byte[3:0];
  assign len_next   = {1'b0, cnt_q, 3'b000} + {3'b000, cnt_q, 1'b0} + {{CNT_W{1'b0}}, digit};
  assign is_open    = (beat_i.data_byte == CH_LIST) || (beat_i.data_byte == CH_DICT);
  assign depth_full = depth_q >= DepthLimit;

  // next parse state
  always_comb begin
    phase_d     = phase_q;
    depth_d     = depth_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    code_d      = code_q;
    off_d       = off_q;
    res_valid_d = res_valid_q && !out_o.ready;
    res_code_d  = res_code_q;
    res_off_d   = res_off_q;
    flag        = 1'b0;
    flag_code   = ERR_NONE;
    fin_code    = ERR_NONE;
    fin_off     = '0;

    if (fire) begin
      pos_d = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

      if (code_q == ERR_NONE) begin
        unique case (phase_q)
          PH_TOP: begin
            if (is_open) begin
              if (depth_full) begin
                flag      = 1'b1;
                flag_code = ERR_DEPTH;
              end else begin
                depth_d = depth_q + DEPTH_W'(1);
                phase_d = PH_VALUE;
              end
            end else begin
              flag      = 1'b1;
              flag_code = ERR_TOP;
            end
          end
          PH_VALUE: begin
            priority if (beat_i.data_byte == CH_END) begin
              depth_d = depth_q - DEPTH_W'(1);
              phase_d = (depth_d == '0) ? PH_DONE : PH_VALUE;
            end else if (is_open) begin
              if (depth_full) begin
                flag      = 1'b1;
                flag_code = ERR_DEPTH;
              end else begin
                depth_d = depth_q + DEPTH_W'(1);
                phase_d = PH_VALUE;
              end
            end else if (beat_i.data_byte == CH_INT) begin
              phase_d = PH_INT;
            end else if (is_digit) begin
              cnt_d   = {{(CNT_W-4){1'b0}}, digit};
              phase_d = PH_LEN;
            end else begin
              flag      = 1'b1;
              flag_code = ERR_BAD_BYTE;
            end
          end
          PH_INT: begin
            if (beat_i.data_byte == CH_END) begin
              phase_d = PH_VALUE;
            end else if (!is_digit && beat_i.data_byte != CH_MINUS) begin
              flag      = 1'b1;
              flag_code = ERR_BAD_BYTE;
            end
          end
          PH_LEN: begin
            priority if (is_digit) begin
              if (|len_next[CNT_W+3:CNT_W]) begin
                flag      = 1'b1;
                flag_code = ERR_LEN_OVF;
              end else begin
                cnt_d = len_next[CNT_W-1:0];
              end
            end else if (beat_i.data_byte == CH_COLON) begin
              phase_d = (cnt_q == '0) ? PH_VALUE : PH_BODY;
            end else begin
              flag      = 1'b1;
              flag_code = ERR_BAD_BYTE;
            end
          end
          PH_BODY: begin
            cnt_d = cnt_q - CNT_W'(1);
            if (cnt_d == '0) begin
              phase_d = PH_VALUE;
            end
          end
          default: begin
            flag      = 1'b1;
            flag_code = ERR_TRAIL;
          end
        endcase
      end

      // latch first error with its position
      if (flag) begin
        code_d = flag_code;
        off_d  = pos_q;
      end

      // final beat: close out the stream and start over
      if (beat_i.last_byte) begin
        fin_code = code_d;
        fin_off  = off_d;
        if (code_d == ERR_NONE && phase_d != PH_DONE) begin
          fin_code = ERR_TRUNC;
          fin_off  = pos_d;
        end
        res_valid_d = 1'b1;
        res_code_d  = fin_code;
        res_off_d   = (fin_code == ERR_NONE) ? '0 : fin_off;
        phase_d     = PH_TOP;
        depth_d     = '0;
        cnt_d       = '0;
        pos_d       = '0;
        code_d      = ERR_NONE;
        off_d       = '0;
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TOP;
      depth_q     <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      code_q      <= ERR_NONE;
      off_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      depth_q     <= depth_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      code_q      <= code_d;
      off_q       <= off_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_code_q <= res_code_d;
    res_off_q  <= res_off_d;
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.stream_valid = (res_code_q == ERR_NONE);
  assign out_o.error_code   = res_code_q;
  assign out_o.error_offset = res_off_q;

`ifndef SYNTH
  // outside any container the depth is zero
  a_depth_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TOP || phase_q == PH_DONE) |-> depth_q == '0)
    else $error("depth nonzero outside a container");

  // depth never passes the limit
  a_depth_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthLimit)
    else $error("nesting depth above limit");

  // a string body always has bytes left
  a_body_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> cnt_q != '0)
    else $error("string body with zero count");

  // the last beat restarts the parser
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && beat_i.last_byte) |=> (phase_q == PH_TOP && pos_q == '0 && code_q == ERR_NONE))
    else $error("parser did not restart after last beat");

  // a valid stream reports offset zero
  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_code_q == ERR_NONE) |-> res_off_q == '0)
    else $error("nonzero offset on valid stream");
`endif

endmodule

FILE: hw/rtl/bencode_stream_validator_unit.sv
// ----------------------------------------------------------------------------
// bencode_stream_validator_unit
// Structural checker for a bencoded byte stream with a result per stream.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and reports, on the beat flagged last, whether the
// stream is well formed, the first error code and its byte offset. Each byte
// is held in the input register and is parsed on its way out of it into the
// parse state; the result of a stream is loaded onto out_o at the same edge at
// which its last byte leaves the input register. Throughput is one byte per
// cycle, set by the parse-state update; input stalls only when a stream ends
// while the previous result is still waiting to be taken.
module bencode_stream_validator_unit import bsv_pkg::*; #(
  parameter int unsigned MAX_DEPTH = BSV_MAX_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsv_byte_if.sink     in_i,
  bsv_result_if.source out_o
);

  logic              in_valid_q;
  logic [DATA_W-1:0] in_byte_q;
  logic              in_last_q;
  logic              beat_ready;
  byte_beat_t        beat;

  // input register accepts while empty or draining
  assign in_i.ready = !in_valid_q || beat_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  assign beat.valid     = in_valid_q;
  assign beat.data_byte = in_byte_q;
  assign beat.last_byte = in_last_q;

  // parse state and result register
  bsv_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .beat_ready_o (beat_ready),
    .out_o        (out_o)
  );

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bencode_stream_validator_unit: drives byte streams
// over the input channel with random gaps, predicts the per-stream verdict
// with a behavioral parser or takes it from the directed table, and compares
// every result beat field by field.
module tb_top import bsv_pkg::*; ();

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_BYTES   = 1290;

  // parser phases of the behavioral tracker
  typedef enum logic [2:0] {
    SCAN_TOP, SCAN_VALUE, SCAN_INT, SCAN_LEN, SCAN_BODY, SCAN_DONE
  } scan_e;

  typedef struct packed {
    logic             ok;
    err_code_e        code;
    logic [POS_W-1:0] off;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  bsv_byte_if   in_if ();
  bsv_result_if out_if ();

  bencode_stream_validator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock, period 12
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  verdict_t          verdict_q[$];
  logic [DATA_W-1:0] frame_q[$];
  int                mismatches   = 0;
  int                stall_cycles = 0;
  logic              steady       = 1'b0;

  // directed streams
  string    dir_text[$];
  logic     dir_fixed[$];
  verdict_t dir_want[$];

  // tracker state
  scan_e             scan_phase;
  logic [DEPTH_W-1:0] scan_depth;
  logic [CNT_W-1:0]  str_left;
  logic [POS_W-1:0]  scan_pos;
  err_code_e         err_seen;
  logic [POS_W-1:0]  err_at;

  function automatic void clear_tracker();
    scan_phase = SCAN_TOP;
    scan_depth = '0;
    str_left   = '0;
    scan_pos   = '0;
    err_seen   = ERR_NONE;
    err_at     = '0;
  endfunction

  function automatic logic is_num(logic [DATA_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // only the first error of a stream is kept
  function automatic void note_error(err_code_e c, logic [POS_W-1:0] where);
    if (err_seen == ERR_NONE) begin
      err_seen = c;
      err_at   = where;
    end
  endfunction

  function automatic void enter_level(logic [POS_W-1:0] where);
    if (int'(scan_depth) + 1 > int'(BSV_MAX_DEPTH)) begin
      note_error(ERR_DEPTH, where);
    end else begin
      scan_depth = scan_depth + DEPTH_W'(1);
      scan_phase = SCAN_VALUE;
    end
  endfunction

  function automatic void parse_byte(logic [DATA_W-1:0] b, logic [POS_W-1:0] where);
    logic [63:0]       wide;
    logic [DATA_W-1:0] digit;
    digit = b - CH_ZERO;
    case (scan_phase)
      SCAN_TOP: begin
        if (b == CH_LIST || b == CH_DICT) enter_level(where);
        else note_error(ERR_TOP, where);
      end
      SCAN_VALUE: begin
        if (b == CH_END) begin
          scan_depth = scan_depth - DEPTH_W'(1);
          scan_phase = (scan_depth == '0) ? SCAN_DONE : SCAN_VALUE;
        end else if (b == CH_LIST || b == CH_DICT) begin
          enter_level(where);
        end else if (b == CH_INT) begin
          scan_phase = SCAN_INT;
        end else if (is_num(b)) begin
          str_left   = {24'd0, digit};
          scan_phase = SCAN_LEN;
        end else begin
          note_error(ERR_BAD_BYTE, where);
        end
      end
      SCAN_INT: begin
        if (b == CH_END) scan_phase = SCAN_VALUE;
        else if (!is_num(b) && b != CH_MINUS) note_error(ERR_BAD_BYTE, where);
      end
      SCAN_LEN: begin
        if (is_num(b)) begin
          wide = {32'd0, str_left} * 64'd10 + {56'd0, digit};
          if (wide > 64'h0000_0000_FFFF_FFFF) note_error(ERR_LEN_OVF, where);
          else str_left = wide[31:0];
        end else if (b == CH_COLON) begin
          scan_phase = (str_left == '0) ? SCAN_VALUE : SCAN_BODY;
        end else begin
          note_error(ERR_BAD_BYTE, where);
        end
      end
      SCAN_BODY: begin
        str_left = str_left - CNT_W'(1);
        if (str_left == '0) scan_phase = SCAN_VALUE;
      end
      default: note_error(ERR_TRAIL, where);
    endcase
  endfunction

  // advance the tracker by one accepted beat; a verdict comes on the last beat
  function automatic void track_byte(input logic [DATA_W-1:0] b, input logic l,
                                     output logic has, output verdict_t v);
    logic [POS_W-1:0] where;
    where = scan_pos;
    if (err_seen == ERR_NONE) parse_byte(b, where);
    if (scan_pos != '1) scan_pos = scan_pos + POS_W'(1);
    has = l;
    v   = '0;
    if (l) begin
      if (err_seen == ERR_NONE && scan_phase != SCAN_DONE) note_error(ERR_TRUNC, scan_pos);
      v.ok   = (err_seen == ERR_NONE);
      v.code = err_seen;
      v.off  = (err_seen == ERR_NONE) ? '0 : err_at;
      clear_tracker();
    end
  endfunction

  task automatic add_row(input string t, input logic fixed, input logic ok,
                         input err_code_e c, input logic [POS_W-1:0] off);
    verdict_t v;
    v.ok   = ok;
    v.code = c;
    v.off  = off;
    dir_text.push_back(t);
    dir_fixed.push_back(fixed);
    dir_want.push_back(v);
  endtask

  // random well-formed value, nesting limited by level
  function automatic void grow_value(int level);
    int          kind;
    int          n;
    logic [31:0] len;
    string       digits;
    kind = (level >= 4) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    case (kind)
      0: begin
        frame_q.push_back(CH_INT);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) frame_q.push_back(CH_MINUS);
          else frame_q.push_back(CH_ZERO + DATA_W'($urandom_range(0, 9)));
        end
        frame_q.push_back(CH_END);
      end
      1: begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 6);
        digits = $sformatf("%0d", len);
        if ($urandom_range(0, 7) == 0) frame_q.push_back(CH_ZERO);
        for (int i = 0; i < digits.len(); i++) frame_q.push_back(digits[i]);
        frame_q.push_back(CH_COLON);
        repeat (len) frame_q.push_back(DATA_W'($urandom_range(0, 255)));
      end
      default: begin
        frame_q.push_back($urandom_range(0, 1) ? CH_LIST : CH_DICT);
        n = $urandom_range(0, 3);
        repeat (n) grow_value(level + 1);
        frame_q.push_back(CH_END);
      end
    endcase
  endfunction

  function automatic void grow_container();
    int n;
    frame_q.push_back($urandom_range(0, 1) ? CH_LIST : CH_DICT);
    n = $urandom_range(1, 5);
    repeat (n) grow_value(1);
    frame_q.push_back(CH_END);
  endfunction

  // one random stream: mostly well formed, some deep, broken or noise
  function automatic void build_stream();
    int mode;
    int k;
    int pick;
    frame_q.delete();
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      grow_container();
    end else if (mode < 75) begin
      k = $urandom_range(60, 66);
      repeat (k) frame_q.push_back($urandom_range(0, 1) ? CH_LIST : CH_DICT);
      if ($urandom_range(0, 1)) grow_value(3);
      repeat (k) frame_q.push_back(CH_END);
    end else if (mode < 78) begin
      frame_q.push_back(CH_LIST);
      frame_q.push_back(CH_ZERO + DATA_W'($urandom_range(1, 9)));
      k = $urandom_range(9, 11);
      repeat (k) frame_q.push_back(CH_ZERO + DATA_W'($urandom_range(0, 9)));
      frame_q.push_back(CH_COLON);
    end else if (mode < 88) begin
      grow_container();
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
        void'(frame_q.pop_back());
      end else if (pick == 1) begin
        frame_q.push_back(DATA_W'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(0, frame_q.size() - 1);
        frame_q[k] = DATA_W'($urandom_range(0, 255));
      end
    end else begin
      k = $urandom_range(1, 6);
      repeat (k) frame_q.push_back(DATA_W'($urandom_range(0, 255)));
    end
    if (frame_q.size() == 0) frame_q.push_back(DATA_W'($urandom_range(0, 255)));
  endfunction

  // send one beat with random gaps ahead of it; predict on acceptance
  task automatic push_beat(input logic [DATA_W-1:0] b, input logic l,
                           input logic fixed, input verdict_t want);
    logic     has;
    verdict_t got;
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    track_byte(b, l, has, got);
    if (has) verdict_q.push_back(fixed ? want : got);
  endtask

  // hold the sender until every pending verdict has come back
  task automatic drain_verdicts();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (verdict_q.size() != 0);
  endtask

  // result sink with random back-pressure
  initial out_if.ready = 1'b0;
  always @(posedge clk_i) begin
    out_if.ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  // result checker and stall counter
  always @(posedge clk_i) begin
    verdict_t want;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (out_if.valid && out_if.ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result beat valid=%0b code=%0d offset=%0d", $time,
                 out_if.stream_valid, out_if.error_code, out_if.error_offset);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (out_if.stream_valid !== want.ok) begin
          $display("%0t: stream_valid expected %0b actual %0b", $time, want.ok,
                   out_if.stream_valid);
          mismatches++;
        end
        if (out_if.error_code !== want.code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, want.code,
                   out_if.error_code);
          mismatches++;
        end
        if (out_if.error_offset !== want.off) begin
          $display("%0t: error_offset expected %0d actual %0d", $time, want.off,
                   out_if.error_offset);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // stimulus
  initial begin
    string    deep;
    int       n;
    int       sent;
    int       streams;
    verdict_t none;
    none            = '0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    clear_tracker();

    add_row("le", 1'b1, 1'b1, ERR_NONE, 0);
    add_row("de", 1'b1, 1'b1, ERR_NONE, 0);
    add_row("x", 1'b1, 1'b0, ERR_TOP, 0);
    add_row("\377e", 1'b1, 1'b0, ERR_TOP, 0);
    add_row("i1e", 1'b1, 1'b0, ERR_TOP, 0);
    add_row("li-5eiei9-9ee", 1'b1, 1'b1, ERR_NONE, 0);
    add_row("l0:3:abc4:\377\377\377\377e", 1'b0, 1'b0, ERR_NONE, 0);
    add_row("d3:keyli1ei-2eed0:leee", 1'b0, 1'b0, ERR_NONE, 0);
    add_row("l", 1'b1, 1'b0, ERR_TRUNC, 1);
    add_row("li12", 1'b1, 1'b0, ERR_TRUNC, 4);
    add_row("leX", 1'b1, 1'b0, ERR_TRAIL, 2);
    add_row("l:e", 1'b1, 1'b0, ERR_BAD_BYTE, 1);
    add_row("lxle", 1'b1, 1'b0, ERR_BAD_BYTE, 1);
    add_row("l4294967296:", 1'b1, 1'b0, ERR_LEN_OVF, 10);
    add_row("l4294967295:", 1'b1, 1'b0, ERR_TRUNC, 12);
    // deepest legal nesting, then one level too many
    deep = "";
    repeat (BSV_MAX_DEPTH) deep = {deep, "l"};
    add_row({deep, "i0e"}, 1'b0, 1'b0, ERR_NONE, 0);
    deep = "";
    repeat (BSV_MAX_DEPTH) deep = {deep, "l"};
    repeat (BSV_MAX_DEPTH) deep = {deep, "e"};
    add_row(deep, 1'b1, 1'b1, ERR_NONE, 0);
    deep = "";
    repeat (BSV_MAX_DEPTH + 1) deep = {deep, "d"};
    add_row(deep, 1'b1, 1'b0, ERR_DEPTH, BSV_MAX_DEPTH);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed streams
    foreach (dir_text[r]) begin
      n = dir_text[r].len();
      for (int i = 0; i < n; i++)
        push_beat(dir_text[r][i], i == n - 1, dir_fixed[r], dir_want[r]);
    end
    drain_verdicts();

    // random streams
    sent    = 0;
    streams = 0;
    while (sent < RAND_BYTES) begin
      steady = (streams >= 30 && streams < 70);
      build_stream();
      foreach (frame_q[i])
        push_beat(frame_q[i], i == frame_q.size() - 1, 1'b0, none);
      sent += frame_q.size();
      streams++;
      if (streams % 40 == 0) drain_verdicts();
    end
    steady = 1'b0;

    in_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && verdict_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bsv_pkg.sv
hw/rtl/bsv_if.sv
hw/rtl/bsv_parser.sv
hw/rtl/bencode_stream_validator_unit.sv
tb/tb_top.sv
